### hdl/sact_pkg.sv
package sact_pkg;
   localparam int NumSets   = 64;
   localparam int NumWays   = 4;
   localparam int LineBytes = 16;
   localparam int AddrBits  = 32;
   localparam int OffBits   = $clog2(LineBytes);
   localparam int SetBits   = (NumSets > 1) ? $clog2(NumSets) : 1;
   localparam int WayBits   = (NumWays > 1) ? $clog2(NumWays) : 1;
   localparam int TagBits   = AddrBits - OffBits - ((NumSets > 1) ? $clog2(NumSets) : 0);
   localparam int QDepth    = 2;

   typedef logic [31:0] stamp_type;
   typedef logic [TagBits-1:0] tag_type;
   typedef logic [SetBits-1:0] set_type;

   // one classified access travelling from front to back
   typedef struct packed {
      set_type set;
      tag_type tag;
   } access_type;

   function automatic access_type split_addr(input logic [31:0] addr);
      access_type a;
      logic [63:0] line_no;
      line_no = 64'(addr) >> OffBits;
      a.set = SetBits'(line_no % NumSets);
      a.tag = TagBits'(line_no / NumSets);
      return a;
   endfunction
endpackage

### hdl/sact_front.sv
module sact_front (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [31:0] req_address,
   output logic q_valid,
   input  logic q_ready,
   output sact_pkg::access_type q_data
);
   import sact_pkg::*;

   localparam int CntBits = $clog2(QDepth + 1);
   localparam int PtrBits = (QDepth > 1) ? $clog2(QDepth) : 1;

   access_type mem_ff [QDepth];
   logic [PtrBits-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [CntBits-1:0] cnt_ff, cnt_in;
   logic push, pop;

   assign req_ready = (cnt_ff != CntBits'(QDepth));
   assign q_valid   = (cnt_ff != '0);
   assign q_data    = mem_ff[rp_ff];
   assign push = req_valid && req_ready;
   assign pop  = q_valid && q_ready;

   // pointer and fill count
   always_comb begin
      wp_in  = push ? ((wp_ff == PtrBits'(QDepth-1)) ? '0 : wp_ff + 1'b1) : wp_ff;
      rp_in  = pop  ? ((rp_ff == PtrBits'(QDepth-1)) ? '0 : rp_ff + 1'b1) : rp_ff;
      cnt_in = cnt_ff + CntBits'(push) - CntBits'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= split_addr(req_address);
   end

   a_no_over: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CntBits'(QDepth)) else $error("queue overflow");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> cnt_ff != '0) else $error("pop of empty queue");
   a_cnt_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> cnt_ff == $past(cnt_ff) + 1'b1) else $error("count slip");
endmodule

### hdl/sact_back.sv
module sact_back (
   input  logic clock,
   input  logic reset,
   input  logic policy,
   input  logic q_valid,
   output logic q_ready,
   input  sact_pkg::access_type q_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic rsp_hit,
   output logic [1:0] rsp_way_used,
   output logic rsp_evicted,
   output logic [31:0] rsp_hits_so_far,
   output logic [31:0] rsp_misses_so_far
);
   import sact_pkg::*;

   // per-way tag and stamp stores, valid bits in flops
   tag_type   tags_mem   [NumWays][NumSets];
   stamp_type stamps_mem [NumWays][NumSets];
   logic [NumWays-1:0] valid_ff [NumSets];

   tag_type   rd_tag   [NumWays];
   stamp_type rd_stamp [NumWays];
   logic [NumWays-1:0] rd_valid;
   access_type cur_ff;
   logic busy_ff, busy_in;
   logic look_ff, look_in;
   stamp_type clk_ff, clk_in, hits_ff, hits_in, miss_ff, miss_in;
   logic ov_ff, ov_in;
   logic take, fin;
   logic hit;
   logic [WayBits-1:0] way, hway, fway, vway;
   logic free;
   stamp_type best;

   // one item at a time: read, then update, then the result is held until taken
   assign q_ready = !busy_ff && !ov_ff;
   assign take = q_valid && q_ready;
   assign fin  = look_ff;

   always_ff @(posedge clock) begin
      if (take) begin
         cur_ff <= q_data;
         for (int w = 0; w < NumWays; w++) begin
            rd_tag[w]   <= tags_mem[w][q_data.set];
            rd_stamp[w] <= stamps_mem[w][q_data.set];
         end
         rd_valid <= valid_ff[q_data.set];
      end
   end

   // compare, free-way and victim search
   always_comb begin
      hit = 1'b0; hway = '0; free = 1'b0; fway = '0;
      vway = '0; best = rd_stamp[0];
      for (int w = NumWays-1; w >= 0; w--) begin
         if (rd_valid[w] && rd_tag[w] == cur_ff.tag) begin
            hit = 1'b1; hway = WayBits'(w);
         end
         if (!rd_valid[w]) begin
            free = 1'b1; fway = WayBits'(w);
         end
      end
      for (int w = 1; w < NumWays; w++) begin
         if (rd_stamp[w] < best) begin
            best = rd_stamp[w]; vway = WayBits'(w);
         end
      end
      way = hit ? hway : (free ? fway : vway);
   end

   always_comb begin
      busy_in = take ? 1'b1 : (fin ? 1'b0 : busy_ff);
      look_in = take;
      clk_in  = clk_ff; hits_in = hits_ff; miss_in = miss_ff;
      ov_in   = ov_ff;
      if (fin) begin
         if (clk_ff != '1) clk_in = clk_ff + 1'b1;
         if (hit && hits_ff != '1) hits_in = hits_ff + 1'b1;
         if (!hit && miss_ff != '1) miss_in = miss_ff + 1'b1;
         ov_in = 1'b1;
      end else if (rsp_valid && rsp_ready) begin
         ov_in = 1'b0;
      end
   end

   logic [31:0] stamp_now;
   assign stamp_now = (clk_ff != '1) ? clk_ff + 1'b1 : clk_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; look_ff <= 1'b0; ov_ff <= 1'b0;
         clk_ff <= '0; hits_ff <= '0; miss_ff <= '0;
         for (int s = 0; s < NumSets; s++) valid_ff[s] <= '0;
      end else begin
         busy_ff <= busy_in; look_ff <= look_in; ov_ff <= ov_in;
         clk_ff <= clk_in; hits_ff <= hits_in; miss_ff <= miss_in;
         if (fin && !hit) valid_ff[cur_ff.set][way] <= 1'b1;
      end
      if (fin && !hit) tags_mem[way][cur_ff.set] <= cur_ff.tag;
      if (fin && (!hit || !policy)) stamps_mem[way][cur_ff.set] <= stamp_now;
      if (fin) begin
         rsp_hit      <= hit;
         rsp_way_used <= 2'(32'(way));
         rsp_evicted  <= !hit && !free;
      end
   end

   assign rsp_valid = ov_ff;
   assign rsp_hits_so_far = hits_ff;
   assign rsp_misses_so_far = miss_ff;

   a_one_line: assert property (@(posedge clock) disable iff (reset)
      look_ff |-> busy_ff) else $error("lookup without item");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      take |-> !busy_ff && !rsp_valid) else $error("take while busy");
   a_evict_miss: assert property (@(posedge clock) disable iff (reset)
      fin |=> !(rsp_hit && rsp_evicted)) else $error("evict on hit");
endmodule

### hdl/set_assoc_cache_tag_lookup_unit.sv
// Tag directory for one set-associative cache level.
// req channel: one 32-bit address word per access (valid/ready).
// rsp channel: hit, way used, evicted flag and saturating hit/miss totals.
// csr port: write enable plus one data bit; 0 selects LRU, 1 FIFO.
// The front end splits the address into set and tag and queues up to two
// accesses, so requests are taken while the back end works.
// The back end handles each access in turn: the set's ways are read
// into registers, then compared and the line is filled or refreshed.
// The result is registered and held until rsp_ready; the back end takes
// no new access from the queue until that result is accepted, so the
// read-update-respond sequence on the way stores never overlaps between
// accesses.
// Reset clears all valid bits, the access clock and both totals; the
// policy returns to LRU. No clearing pass is needed.
// If rsp_ready is low the result holds and the back end waits; the queue
// keeps accepting until it is full, then req_ready drops.
module set_assoc_cache_tag_lookup_unit (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [31:0] req_address,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic rsp_hit,
   output logic [1:0] rsp_way_used,
   output logic rsp_evicted,
   output logic [31:0] rsp_hits_so_far,
   output logic [31:0] rsp_misses_so_far,
   input  logic csr_write_enable,
   input  logic [0:0] csr_write_data
);
   import sact_pkg::*;

   logic policy_ff;
   logic q_valid, q_ready;
   access_type q_data;

   always_ff @(posedge clock) begin
      if (reset) policy_ff <= 1'b0;
      else if (csr_write_enable) policy_ff <= csr_write_data[0];
   end

   sact_front u_front (.clock, .reset, .req_valid, .req_ready, .req_address,
      .q_valid, .q_ready, .q_data);

   sact_back u_back (.clock, .reset, .policy(policy_ff), .q_valid, .q_ready,
      .q_data, .rsp_valid, .rsp_ready, .rsp_hit, .rsp_way_used, .rsp_evicted,
      .rsp_hits_so_far, .rsp_misses_so_far);
endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import sact_pkg::*;

   localparam int LineCount = NumSets * NumWays;
   localparam logic [31:0] Sat = 32'hFFFF_FFFF;

   typedef enum logic [0:0] {
      POL_LRU  = 1'b0,
      POL_FIFO = 1'b1
   } policy_type;

   // one expected result word
   typedef struct {
      logic        hit;
      logic [1:0]  way;
      logic        evicted;
      logic [31:0] hits;
      logic [31:0] misses;
   } lookup_result_type;

   // one row of the directed table
   typedef struct {
      logic [31:0] address;
      policy_type  policy;
      bit          known;
      logic        hit;
      logic [1:0]  way;
      logic        evicted;
   } access_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [31:0] req_address;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_hit;
   logic [1:0]  rsp_way_used;
   logic        rsp_evicted;
   logic [31:0] rsp_hits_so_far;
   logic [31:0] rsp_misses_so_far;
   logic        csr_write_enable;
   logic [0:0]  csr_write_data;

   // directory copy kept by the testbench
   tag_type     dir_tags [LineCount];
   bit          dir_valid [LineCount];
   stamp_type   dir_stamps [LineCount];
   logic [31:0] access_clock;
   logic [31:0] hit_total;
   logic [31:0] miss_total;
   policy_type  cur_policy;

   lookup_result_type pending_results[$];
   int  error_count = 0;
   int  rsp_count = 0;
   bit  idling_on;
   bit  hold_done = 0;
   int  hold_left = 0;
   tag_type tag_pool [6];

   set_assoc_cache_tag_lookup_unit i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_address       (req_address),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_hit           (rsp_hit),
      .rsp_way_used      (rsp_way_used),
      .rsp_evicted       (rsp_evicted),
      .rsp_hits_so_far   (rsp_hits_so_far),
      .rsp_misses_so_far (rsp_misses_so_far),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   // 8 ns clock
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // look up one address in the directory copy and update it
   function automatic lookup_result_type lookup_access(input logic [31:0] addr);
      lookup_result_type r;
      set_type set_idx;
      tag_type tag;
      int base;
      int way;
      bit found;
      stamp_type best;
      set_idx = addr[OffBits +: SetBits];
      tag     = addr[31 -: TagBits];
      base    = int'(set_idx) * NumWays;
      way     = 0;
      found   = 0;
      r.evicted = 1'b0;
      if (access_clock != Sat) access_clock++;
      for (int w = 0; w < NumWays; w++) begin
         if (!found && dir_valid[base + w] && dir_tags[base + w] == tag) begin
            found = 1;
            way = w;
         end
      end
      if (found) begin
         if (hit_total != Sat) hit_total++;
         if (cur_policy == POL_LRU) dir_stamps[base + way] = access_clock;
      end else begin
         if (miss_total != Sat) miss_total++;
         // lowest free way first, else the oldest stamp
         way = -1;
         for (int w = NumWays - 1; w >= 0; w--) begin
            if (!dir_valid[base + w]) way = w;
         end
         if (way < 0) begin
            way = 0;
            best = dir_stamps[base];
            for (int w = 1; w < NumWays; w++) begin
               if (dir_stamps[base + w] < best) begin
                  best = dir_stamps[base + w];
                  way = w;
               end
            end
            r.evicted = 1'b1;
         end
         dir_tags[base + way]   = tag;
         dir_valid[base + way]  = 1;
         dir_stamps[base + way] = access_clock;
      end
      r.hit    = found;
      r.way    = 2'(way);
      r.hits   = hit_total;
      r.misses = miss_total;
      return r;
   endfunction

   // drive one address word and record what it should produce
   task automatic send_access(input logic [31:0] addr, output lookup_result_type r);
      int gaps;
      gaps = 0;
      if (idling_on) while ($urandom_range(99) < 21) gaps++;
      if (gaps > 0) begin
         req_valid <= 1'b0;
         repeat (gaps) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_address <= addr;
      do @(posedge clock); while (!req_ready);
      r = lookup_access(addr);
      pending_results.push_back(r);
      @(negedge clock);
   endtask

   // switch policy once the block has gone quiet
   task automatic set_policy(input policy_type p);
      req_valid <= 1'b0;
      wait (pending_results.size() == 0);
      repeat (10) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= p;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      cur_policy = p;
   endtask

   function automatic logic [31:0] random_address();
      logic [31:0] a;
      if ($urandom_range(99) < 20) return $urandom;
      a = $urandom;
      a[OffBits +: SetBits] = SetBits'($urandom_range(3));
      a[31 -: TagBits] = tag_pool[$urandom_range(5)];
      return a;
   endfunction

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         error_count++;
      end
   endtask

   // receiver side: random stalls, one long hold-off
   always @(negedge clock) begin
      if (!hold_done && rsp_count >= 350) begin
         hold_done <= 1;
         hold_left <= 300;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !idling_on || ($urandom_range(99) >= 21);
      end
   end

   // result checker
   always @(posedge clock) begin
      lookup_result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_count <= rsp_count + 1;
         if (pending_results.size() == 0) begin
            $error("result word with nothing expected");
            error_count++;
         end else begin
            e = pending_results.pop_front();
            check_field("hit", e.hit, rsp_hit);
            check_field("way_used", e.way, rsp_way_used);
            check_field("evicted", e.evicted, rsp_evicted);
            check_field("hits_so_far", e.hits, rsp_hits_so_far);
            check_field("misses_so_far", e.misses, rsp_misses_so_far);
         end
      end
   end

   // run limit
   initial begin
      #2ms;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      access_row_type rows[$];
      lookup_result_type r;
      policy_type phase_pol[5];
      reset = 1'b1;
      req_valid = 1'b0;
      req_address = '0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      idling_on = 1;
      access_clock = '0;
      hit_total = '0;
      miss_total = '0;
      cur_policy = POL_LRU;
      foreach (dir_valid[i]) begin
         dir_valid[i] = 0;
         dir_tags[i] = '0;
         dir_stamps[i] = '0;
      end
      foreach (tag_pool[i]) tag_pool[i] = tag_type'($urandom);
      tag_pool[0] = '0;
      tag_pool[1] = '1;

      // set 0 fills, LRU victim, extremes, then FIFO victims
      rows = '{
         '{32'h0000_0000, POL_LRU,  1, 1'b0, 2'd0, 1'b0},
         '{32'h0000_0400, POL_LRU,  1, 1'b0, 2'd1, 1'b0},
         '{32'h0000_0800, POL_LRU,  1, 1'b0, 2'd2, 1'b0},
         '{32'h0000_0C00, POL_LRU,  1, 1'b0, 2'd3, 1'b0},
         '{32'h0000_040F, POL_LRU,  1, 1'b1, 2'd1, 1'b0},
         '{32'h0000_1000, POL_LRU,  1, 1'b0, 2'd0, 1'b1},
         '{32'h0000_0005, POL_LRU,  1, 1'b0, 2'd2, 1'b1},
         '{32'hFFFF_FFFF, POL_LRU,  1, 1'b0, 2'd0, 1'b0},
         '{32'hFFFF_FFF0, POL_LRU,  1, 1'b1, 2'd0, 1'b0},
         '{32'h0000_03F0, POL_LRU,  1, 1'b0, 2'd1, 1'b0},
         '{32'h0000_0400, POL_FIFO, 1, 1'b1, 2'd1, 1'b0},
         '{32'h0000_1400, POL_FIFO, 1, 1'b0, 2'd3, 1'b1},
         '{32'h0000_1800, POL_FIFO, 1, 1'b0, 2'd1, 1'b1},
         '{32'hAAAA_AAAA, POL_FIFO, 0, 1'b0, 2'd0, 1'b0},
         '{32'h5555_5555, POL_FIFO, 0, 1'b0, 2'd0, 1'b0},
         '{32'h0000_0000, POL_FIFO, 0, 1'b0, 2'd0, 1'b0}
      };

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table
      foreach (rows[i]) begin
         if (rows[i].policy != cur_policy) set_policy(rows[i].policy);
         send_access(rows[i].address, r);
         if (rows[i].known) begin
            check_field("row hit", rows[i].hit, r.hit);
            check_field("row way_used", rows[i].way, r.way);
            check_field("row evicted", rows[i].evicted, r.evicted);
         end
      end

      // random phases, alternating policy
      phase_pol = '{POL_LRU, POL_FIFO, POL_LRU, POL_FIFO, POL_LRU};
      foreach (phase_pol[p]) begin
         set_policy(phase_pol[p]);
         idling_on = (p != 2);
         repeat (107) send_access(random_address(), r);
      end
      idling_on = 1;
      req_valid <= 1'b0;

      wait (pending_results.size() == 0);
      repeat (20) @(negedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule

### filelist.f
hdl/sact_pkg.sv
hdl/sact_front.sv
hdl/sact_back.sv
hdl/set_assoc_cache_tag_lookup_unit.sv
dv/tb_top.sv
